/* design/rtnh_pkg.sv */
// Shared types and constants for the route table next-hop lookup unit.
`default_nettype none
package rtnh_pkg;

   localparam int ADDR_W  = 32;
   localparam int INDEX_W = 4;
   localparam int PORT_W  = 2;

   // Interfaces that exist; a write naming a higher port is dropped.
   localparam int PORT_COUNT = 4;

   typedef enum logic {
      KIND_WRITE  = 1'b0,
      KIND_LOOKUP = 1'b1
   } kind_type;

   typedef struct packed {
      logic [0:0]         kind;
      logic [INDEX_W-1:0] entry_index;
      logic               entry_valid;
      logic [ADDR_W-1:0]  route_dest;
      logic [ADDR_W-1:0]  route_mask;
      logic [ADDR_W-1:0]  route_gateway;
      logic [PORT_W-1:0]  route_port;
      logic [ADDR_W-1:0]  lookup_addr;
   } req_word_type;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] matched_index;
      logic [PORT_W-1:0]  out_port;
      logic [ADDR_W-1:0]  next_hop_addr;
      logic               used_default;
   } rsp_word_type;

   // Slot load broadcast to every cell.
   typedef struct packed {
      logic               en;
      logic [INDEX_W-1:0] index;
      logic               valid;
      logic [ADDR_W-1:0]  dest;
      logic [ADDR_W-1:0]  mask;
      logic [ADDR_W-1:0]  gateway;
      logic [PORT_W-1:0]  port;
   } slot_write_type;

   // Search token handed from cell to cell.
   typedef struct packed {
      logic               active;
      logic [ADDR_W-1:0]  addr;
      logic               hit;
      logic [INDEX_W-1:0] hit_index;
      logic [PORT_W-1:0]  hit_port;
      logic [ADDR_W-1:0]  hit_gateway;
      logic               dflt;
      logic [INDEX_W-1:0] dflt_index;
      logic [PORT_W-1:0]  dflt_port;
      logic [ADDR_W-1:0]  dflt_gateway;
   } token_type;

endpackage
`default_nettype wire

/* design/rtnh_cell.sv */
// One route slot plus its stage of the search chain.
`default_nettype none
module rtnh_cell #(
   parameter int CELL_INDEX = 0
) (
   input  wire                    clock,
   input  wire                    reset,
   input  rtnh_pkg::slot_write_type slot_write,
   input  rtnh_pkg::token_type     token_in,
   output rtnh_pkg::token_type     token_out
);

   localparam bit REACHABLE = (CELL_INDEX < (1 << rtnh_pkg::INDEX_W));
   localparam logic [rtnh_pkg::INDEX_W-1:0] MY_INDEX = rtnh_pkg::INDEX_W'(CELL_INDEX);

   logic                          valid_ff;
   logic [rtnh_pkg::ADDR_W-1:0]   dest_ff;
   logic [rtnh_pkg::ADDR_W-1:0]   mask_ff;
   logic [rtnh_pkg::ADDR_W-1:0]   gateway_ff;
   logic [rtnh_pkg::PORT_W-1:0]   port_ff;
   logic                          load;
   logic                          specific_match;
   logic                          default_match;
   rtnh_pkg::token_type           token_ff;
   rtnh_pkg::token_type           token_stage_in;

   assign load = REACHABLE && slot_write.en && (slot_write.index == MY_INDEX);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= slot_write.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         dest_ff    <= slot_write.dest;
         mask_ff    <= slot_write.mask;
         gateway_ff <= slot_write.gateway;
         port_ff    <= slot_write.port;
      end
   end

   assign specific_match = valid_ff && (dest_ff != '0)
                           && (((token_in.addr ^ dest_ff) & mask_ff) == '0);
   assign default_match  = valid_ff && (dest_ff == '0);

   // Keep the first hit of each kind; later cells leave it alone.
   always_comb begin
      token_stage_in = token_in;
      if (!token_in.hit && specific_match) begin
         token_stage_in.hit         = 1'b1;
         token_stage_in.hit_index   = MY_INDEX;
         token_stage_in.hit_port    = port_ff;
         token_stage_in.hit_gateway = gateway_ff;
      end
      if (!token_in.dflt && default_match) begin
         token_stage_in.dflt         = 1'b1;
         token_stage_in.dflt_index   = MY_INDEX;
         token_stage_in.dflt_port    = port_ff;
         token_stage_in.dflt_gateway = gateway_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff.active <= 1'b0;
      end else begin
         token_ff.active <= token_in.active;
      end
      token_ff.addr         <= token_stage_in.addr;
      token_ff.hit          <= token_stage_in.hit;
      token_ff.hit_index    <= token_stage_in.hit_index;
      token_ff.hit_port     <= token_stage_in.hit_port;
      token_ff.hit_gateway  <= token_stage_in.hit_gateway;
      token_ff.dflt         <= token_stage_in.dflt;
      token_ff.dflt_index   <= token_stage_in.dflt_index;
      token_ff.dflt_port    <= token_stage_in.dflt_port;
      token_ff.dflt_gateway <= token_stage_in.dflt_gateway;
   end

   assign token_out = token_ff;

endmodule
`default_nettype wire

/* design/route_table_next_hop_lookup_unit.sv */
// Top level of the route table next-hop lookup unit.
`default_nettype none
// Route table with a default route. Each request word is either a slot write
// (kind 0) or an address lookup (kind 1), taken when start is high and busy is
// low. A slot write lands in its cell's registers and produces no response;
// busy stays low, so writes may be issued back to back. Writes with an index
// past the table or a port past the interface count are dropped. A lookup
// launches a search token into a row of TABLE_DEPTH cells, one cell per route
// slot; the token visits one cell per cycle, keeping the first specific match
// and the first default slot it sees. The response word sits on rsp_word for
// exactly one cycle with rsp_strobe high; that cycle follows the token's pass
// through every cell register and then the response register, and it ends at
// the next edge, where it must be captured: there is no backpressure. Busy is
// high from the cycle after a lookup is taken until the strobe cycle, during
// which a new word may already be taken; a new lookup is not taken before the
// last one has left the cell chain. Only slots 0 to 15 can be addressed.
module route_table_next_hop_lookup_unit #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  rtnh_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output rtnh_pkg::rsp_word_type rsp_word
);

   logic                          accept;
   logic                          lookup_accept;
   logic                          busy_ff;
   logic                          busy_in;
   logic                          rsp_strobe_ff;
   logic                          rsp_strobe_in;
   rtnh_pkg::rsp_word_type        rsp_word_ff;
   rtnh_pkg::rsp_word_type        rsp_word_in;
   rtnh_pkg::slot_write_type      slot_write;
   rtnh_pkg::token_type           head_token;
   rtnh_pkg::token_type           chain [TABLE_DEPTH+1];
   rtnh_pkg::token_type           last_token;

   assign accept        = start && !busy_ff;
   assign lookup_accept = accept && (req_word.kind == rtnh_pkg::KIND_LOOKUP);

   // Broadcast slot loads; drop ports past the interface count.
   always_comb begin
      slot_write.en      = accept && (req_word.kind == rtnh_pkg::KIND_WRITE)
                           && (int'(req_word.route_port) < rtnh_pkg::PORT_COUNT);
      slot_write.index   = req_word.entry_index;
      slot_write.valid   = req_word.entry_valid;
      slot_write.dest    = req_word.route_dest;
      slot_write.mask    = req_word.route_mask;
      slot_write.gateway = req_word.route_gateway;
      slot_write.port    = req_word.route_port;
   end

   // Inject a fresh token at the head of the chain.
   always_comb begin
      head_token        = '0;
      head_token.active = lookup_accept;
      head_token.addr   = req_word.lookup_addr;
   end

   assign chain[0] = head_token;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      rtnh_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .slot_write (slot_write),
         .token_in   (chain[i]),
         .token_out  (chain[i+1])
      );
   end

   assign last_token = chain[TABLE_DEPTH];

   // Specific match wins over the default; nothing found gives all zeros.
   always_comb begin
      rsp_word_in = '0;
      if (last_token.hit) begin
         rsp_word_in.found         = 1'b1;
         rsp_word_in.matched_index = last_token.hit_index;
         rsp_word_in.out_port      = last_token.hit_port;
         rsp_word_in.next_hop_addr = (last_token.hit_gateway != '0)
                                     ? last_token.hit_gateway : last_token.addr;
      end else if (last_token.dflt) begin
         rsp_word_in.found         = 1'b1;
         rsp_word_in.matched_index = last_token.dflt_index;
         rsp_word_in.out_port      = last_token.dflt_port;
         rsp_word_in.next_hop_addr = (last_token.dflt_gateway != '0)
                                     ? last_token.dflt_gateway : last_token.addr;
         rsp_word_in.used_default  = 1'b1;
      end
   end

   assign rsp_strobe_in = last_token.active;

   // Hold busy while a token is in the chain; release as it leaves.
   always_comb begin
      busy_in = busy_ff;
      if (busy_ff && last_token.active) begin
         busy_in = 1'b0;
      end else if (lookup_accept) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // A lookup keeps the unit busy until its token leaves the chain.
   a_lookup_sets_busy: assert property (@(posedge clock) disable iff (reset)
      lookup_accept |=> busy)
      else $error("busy not raised after lookup");

   // Only one token in flight, so strobes never come back to back.
   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back response strobes");

   // A miss reports all-zero fields.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_word.found) |-> (rsp_word.matched_index == '0
         && rsp_word.out_port == '0 && rsp_word.next_hop_addr == '0
         && !rsp_word.used_default))
      else $error("miss with nonzero fields");

   // A response only comes out of a busy unit.
   a_strobe_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a lookup in flight");

endmodule
`default_nettype wire

/* test/tb_route_table_next_hop_lookup_unit.sv */
// Self-checking testbench for the route table next-hop lookup unit.
module tb_route_table_next_hop_lookup_unit;

   localparam int TABLE_DEPTH    = 16;
   localparam int RANDOM_WORDS   = 560;
   localparam int WIPE_EVERY     = 160;   // random words between full table wipes
   localparam int WATCHDOG_LIMIT = 400;   // cycles with neither a word taken nor a result
   localparam int DRAIN_CYCLES   = TABLE_DEPTH + 4;
   localparam int REPORT_LIMIT   = 10;

   // One directed row: the word, and the result typed in by hand when it is
   // obvious; all other lookups are checked against the shadow table.
   typedef struct {
      rtnh_pkg::req_word_type word;
      bit                     typed;
      rtnh_pkg::rsp_word_type hop;
   } stim_row_type;

   logic                   clock    = 1'b0;
   logic                   reset    = 1'b1;
   logic                   start    = 1'b0;
   rtnh_pkg::req_word_type req_word = '0;
   logic                   busy;
   logic                   rsp_strobe;
   rtnh_pkg::rsp_word_type rsp_word;

   // Shadow copy of the route table, updated as each write word is taken.
   bit                          shadow_valid   [TABLE_DEPTH];
   logic [rtnh_pkg::ADDR_W-1:0] shadow_dest    [TABLE_DEPTH];
   logic [rtnh_pkg::ADDR_W-1:0] shadow_mask    [TABLE_DEPTH];
   logic [rtnh_pkg::ADDR_W-1:0] shadow_gateway [TABLE_DEPTH];
   logic [rtnh_pkg::PORT_W-1:0] shadow_port    [TABLE_DEPTH];

   rtnh_pkg::rsp_word_type expected_hops [$];   // next-hop results still owed by the block
   stim_row_type           directed_rows [$];
   int                     mismatch_count = 0;
   int                     stall_cycles   = 0;
   int                     no_gap_left    = 0;  // words left in a back-to-back stretch

   route_table_next_hop_lookup_unit #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply a slot write to the shadow table; drop it when the slot or the
   // port does not exist, as the block does.
   function automatic void load_route_slot(rtnh_pkg::req_word_type w);
      if (w.entry_index < TABLE_DEPTH && w.route_port < rtnh_pkg::PORT_COUNT) begin
         shadow_valid[w.entry_index]   = w.entry_valid;
         shadow_dest[w.entry_index]    = w.route_dest;
         shadow_mask[w.entry_index]    = w.route_mask;
         shadow_gateway[w.entry_index] = w.route_gateway;
         shadow_port[w.entry_index]    = w.route_port;
      end
   endfunction

   // Work out the next hop for one address: first specific match by index,
   // else the first zero-destination slot, else an all-zero miss.
   function automatic rtnh_pkg::rsp_word_type predict_route(
         logic [rtnh_pkg::ADDR_W-1:0] addr);
      rtnh_pkg::rsp_word_type hop;
      int                     pick;
      bit                     dflt;
      hop  = '0;
      pick = -1;
      dflt = 1'b0;
      for (int i = 0; i < TABLE_DEPTH && pick < 0; i++) begin
         if (shadow_valid[i] && shadow_dest[i] != '0 &&
             (addr & shadow_mask[i]) == (shadow_dest[i] & shadow_mask[i])) begin
            pick = i;
         end
      end
      for (int i = 0; i < TABLE_DEPTH && pick < 0; i++) begin
         if (shadow_valid[i] && shadow_dest[i] == '0) begin
            pick = i;
            dflt = 1'b1;
         end
      end
      if (pick >= 0) begin
         hop.found         = 1'b1;
         hop.matched_index = pick[rtnh_pkg::INDEX_W-1:0];
         hop.out_port      = shadow_port[pick];
         hop.next_hop_addr = (shadow_gateway[pick] != '0) ? shadow_gateway[pick] : addr;
         hop.used_default  = dflt;
      end
      return hop;
   endfunction

   function automatic rtnh_pkg::req_word_type route_write(int slot, bit valid,
         logic [rtnh_pkg::ADDR_W-1:0] dest, mask, gateway,
         logic [rtnh_pkg::PORT_W-1:0] port);
      rtnh_pkg::req_word_type w;
      w               = '0;
      w.kind          = rtnh_pkg::KIND_WRITE;
      w.entry_index   = slot[rtnh_pkg::INDEX_W-1:0];
      w.entry_valid   = valid;
      w.route_dest    = dest;
      w.route_mask    = mask;
      w.route_gateway = gateway;
      w.route_port    = port;
      return w;
   endfunction

   function automatic rtnh_pkg::req_word_type route_query(logic [rtnh_pkg::ADDR_W-1:0] addr);
      rtnh_pkg::req_word_type w;
      w             = '0;
      w.kind        = rtnh_pkg::KIND_LOOKUP;
      w.lookup_addr = addr;
      return w;
   endfunction

   function automatic rtnh_pkg::rsp_word_type hop_of(int slot,
         logic [rtnh_pkg::PORT_W-1:0] port, logic [rtnh_pkg::ADDR_W-1:0] via_addr, bit dflt);
      rtnh_pkg::rsp_word_type hop;
      hop.found         = 1'b1;
      hop.matched_index = slot[rtnh_pkg::INDEX_W-1:0];
      hop.out_port      = port;
      hop.next_hop_addr = via_addr;
      hop.used_default  = dflt;
      return hop;
   endfunction

   function automatic void add_row(rtnh_pkg::req_word_type w, bit typed,
                                   rtnh_pkg::rsp_word_type hop);
      directed_rows.push_back('{word: w, typed: typed, hop: hop});
   endfunction

   // Draw one random word. Writes use mostly prefix masks and sometimes a
   // zero destination; many lookups aim inside a live slot's prefix so that
   // hits, priority and the default route all get exercised.
   function automatic rtnh_pkg::req_word_type random_word();
      rtnh_pkg::req_word_type      w;
      int                          len;
      int                          target;
      logic [rtnh_pkg::ADDR_W-1:0] mask;
      w.kind          = ($urandom_range(0, 99) < 35) ? rtnh_pkg::KIND_WRITE
                                                     : rtnh_pkg::KIND_LOOKUP;
      w.entry_index   = rtnh_pkg::INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
      w.entry_valid   = ($urandom_range(0, 3) != 0);
      w.route_dest    = ($urandom_range(0, 9) == 0) ? '0 : $urandom;
      len             = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32)
                                                    : $urandom_range(16, 32);
      w.route_mask    = ($urandom_range(0, 4) == 0) ? $urandom
                                                    : ~(32'hFFFF_FFFF >> len);
      w.route_gateway = ($urandom_range(0, 2) == 0) ? '0 : $urandom;
      w.route_port    = rtnh_pkg::PORT_W'($urandom_range(0, 3));
      w.lookup_addr   = $urandom;
      if (w.kind == rtnh_pkg::KIND_LOOKUP && $urandom_range(0, 9) < 6) begin
         target = $urandom_range(0, TABLE_DEPTH - 1);
         if (shadow_valid[target]) begin
            mask          = shadow_mask[target];
            w.lookup_addr = (shadow_dest[target] & mask) | ($urandom & ~mask);
         end
      end
      return w;
   endfunction

   // Hand one word to the block. Draw an idle gap first, except inside
   // a back-to-back stretch; hold start high until an edge finds busy low,
   // then record what the word owes.
   task automatic send_word(rtnh_pkg::req_word_type w, bit typed,
                            rtnh_pkg::rsp_word_type hop);
      int gap;
      if (no_gap_left > 0) begin
         no_gap_left--;
         gap = 0;
      end else begin
         gap = $urandom_range(0, 3);
         if ($urandom_range(0, 19) == 0) begin
            no_gap_left = $urandom_range(8, 24);
         end
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      if (w.kind == rtnh_pkg::KIND_LOOKUP) begin
         expected_hops.push_back(typed ? hop : predict_route(w.lookup_addr));
      end else begin
         load_route_slot(w);
      end
   endtask

   initial begin : stimulus
      rtnh_pkg::rsp_word_type miss;
      rtnh_pkg::req_word_type w;
      miss = '0;

      // Empty table: every lookup misses, whatever the address.
      add_row(route_query(32'h0000_0000), 1'b1, miss);
      add_row(route_query(32'hFFFF_FFFF), 1'b1, miss);
      // Default route in the last slot, gateway all ones, top port.
      add_row(route_write(15, 1'b1, 32'h0, 32'h0, 32'hFFFF_FFFF, 2'd3), 1'b0, miss);
      add_row(route_query(32'h1234_5678), 1'b1, hop_of(15, 2'd3, 32'hFFFF_FFFF, 1'b1));
      // Host route in slot 0, directly attached: next hop is the address itself.
      add_row(route_write(0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 2'd0), 1'b0, miss);
      add_row(route_query(32'hFFFF_FFFF), 1'b1, hop_of(0, 2'd0, 32'hFFFF_FFFF, 1'b0));
      add_row(route_query(32'hFFFF_FFFE), 1'b1, hop_of(15, 2'd3, 32'hFFFF_FFFF, 1'b1));
      // Overlapping prefixes: the lower slot wins; here it also holds the longer prefix.
      add_row(route_write(3, 1'b1, 32'h0A00_0000, 32'hFF00_0000, 32'h0, 2'd1), 1'b0, miss);
      add_row(route_query(32'h0A0B_0C0D), 1'b0, miss);
      add_row(route_write(2, 1'b1, 32'h0A0B_0000, 32'hFFFF_0000, 32'hC0A8_0001, 2'd2),
              1'b0, miss);
      add_row(route_query(32'h0A0B_0C0D), 1'b0, miss);
      // Second default at a lower slot; a zero destination never counts as specific.
      add_row(route_write(1, 1'b1, 32'h0, 32'hFFFF_FFFF, 32'h0, 2'd2), 1'b0, miss);
      add_row(route_query(32'h0000_0000), 1'b0, miss);
      // Clear slots: fields load but the slot no longer matches.
      add_row(route_write(1, 1'b0, 32'h0A0B_0C0D, 32'hFFFF_FFFF, 32'h0101_0101, 2'd1),
              1'b0, miss);
      add_row(route_query(32'h0A0B_0C0D), 1'b0, miss);
      add_row(route_write(2, 1'b0, 32'h0A0B_0000, 32'hFFFF_0000, 32'hC0A8_0001, 2'd2),
              1'b0, miss);
      add_row(route_query(32'hC000_0000), 1'b0, miss);
      // Lookup carrying junk write fields: the table must not change.
      w               = route_query(32'h0A00_0001);
      w.entry_index   = '1;
      w.entry_valid   = 1'b1;
      w.route_dest    = '1;
      w.route_mask    = '1;
      w.route_gateway = '1;
      w.route_port    = '1;
      add_row(w, 1'b0, miss);
      // Write carrying a junk address; drop the default route with it.
      w             = route_write(15, 1'b0, 32'h0, 32'h0, 32'h0, 2'd0);
      w.lookup_addr = '1;
      add_row(w, 1'b0, miss);
      add_row(route_query(32'h5555_5555), 1'b1, miss);
      // Zero mask with a nonzero destination matches any address.
      add_row(route_write(7, 1'b1, 32'h1234_5678, 32'h0, 32'h0102_0304, 2'd3), 1'b0, miss);
      add_row(route_query(32'hDEAD_BEEF), 1'b0, miss);
      add_row(route_query(32'h0A00_0001), 1'b0, miss);
      add_row(route_query(32'hFFFF_FFFF), 1'b0, miss);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         send_word(directed_rows[r].word, directed_rows[r].typed, directed_rows[r].hop);
      end

      // Random words; wipe the table now and then so misses show up again.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % WIPE_EVERY == 0) begin
            for (int s = 0; s < TABLE_DEPTH; s++) begin
               send_word(route_write(s, 1'b0, $urandom, $urandom, $urandom,
                                     rtnh_pkg::PORT_W'($urandom_range(0, 3))),
                         1'b0, miss);
            end
         end
         send_word(random_word(), 1'b0, miss);
      end
      start <= 1'b0;

      // Wait for every owed result, then hold a little longer for strays.
      while (expected_hops.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Check each strobed result against the oldest owed next hop.
   always @(posedge clock) begin : check_hops
      rtnh_pkg::rsp_word_type want;
      if (!reset && rsp_strobe) begin
         if (expected_hops.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected result word: found=%0b index=%0d port=%0d hop=%h dflt=%0b",
                        rsp_word.found, rsp_word.matched_index, rsp_word.out_port,
                        rsp_word.next_hop_addr, rsp_word.used_default);
            end
         end else begin
            want = expected_hops.pop_front();
            if (want.found !== rsp_word.found ||
                want.matched_index !== rsp_word.matched_index ||
                want.out_port !== rsp_word.out_port ||
                want.next_hop_addr !== rsp_word.next_hop_addr ||
                want.used_default !== rsp_word.used_default) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("next hop mismatch at %0t", $realtime);
                  $display("  expected found=%0b index=%0d port=%0d hop=%h dflt=%0b",
                           want.found, want.matched_index, want.out_port,
                           want.next_hop_addr, want.used_default);
                  $display("  actual   found=%0b index=%0d port=%0d hop=%h dflt=%0b",
                           rsp_word.found, rsp_word.matched_index, rsp_word.out_port,
                           rsp_word.next_hop_addr, rsp_word.used_default);
               end
            end
         end
      end
   end

   // Watchdog: end the run if nothing moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
